// ----- design/rsi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_pkg - shared types and constants for the ray / sphere intersection block
// Holds the fixed-point widths, the payload structs that pass between the
// pipeline sections, and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int FRAC_BITS = 16;

  localparam int COORD_W  = 32;
  localparam int DIR_W    = 18;
  localparam int RAD_IN_W = 31;

  localparam int W_W      = COORD_W + 1;        // origin minus centre
  localparam int PROD_W   = DIR_W + W_W;        // one term of d.w
  localparam int DOT_W    = PROD_W + 2;         // d.w
  localparam int WSQ_W    = 2 * W_W;            // one term of w.w
  localparam int WW_W     = WSQ_W + 2;          // w.w
  localparam int RR_W     = 2 * RAD_IN_W;       // r*r
  localparam int MAG_LO_W = 32;
  localparam int MAG_HI_W = DOT_W - MAG_LO_W;
  localparam int DSQ_W    = 2 * DOT_W;          // dot squared
  localparam int NEG_W    = WW_W + 2 * FRAC_BITS;
  localparam int DIFF_W   = ((DSQ_W > NEG_W) ? DSQ_W : NEG_W) + 2;
  localparam int DQ_W     = DIFF_W - 1;         // non-negative discriminant
  localparam int SQ_W     = (DQ_W + 1) / 2;     // root width
  localparam int RADIC_W  = 2 * SQ_W;
  localparam int REM_W    = SQ_W + 2;
  localparam int T_W      = (((SQ_W + 1) > DOT_W) ? (SQ_W + 1) : DOT_W) + 1;
  localparam int DPROD_W  = COORD_W + DIR_W;
  localparam int PT_W     = ((COORD_W > (DPROD_W - FRAC_BITS)) ?
                             COORD_W : (DPROD_W - FRAC_BITS)) + 1;
  localparam int SAT_W    = 64;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIR_W-1:0]   dir_t;
  typedef logic signed [DOT_W-1:0]   dot_t;

  typedef struct packed {
    coord_t [2:0]        origin;
    dir_t   [2:0]        dir;
    coord_t [2:0]        center;
    logic [RAD_IN_W-1:0] radius;
  } in_t;

  typedef struct packed {
    logic         hit;
    coord_t       distance;
    coord_t [2:0] point;
  } out_t;

  // Front section to square root.
  typedef struct packed {
    logic            hit;
    logic [DQ_W-1:0] dq;
    dot_t            dot;
    coord_t [2:0]    origin;
    dir_t   [2:0]    dir;
  } sq_in_t;

  // Square root to back section.
  typedef struct packed {
    logic            hit;
    logic [SQ_W-1:0] root;
    dot_t            dot;
    coord_t [2:0]    origin;
    dir_t   [2:0]    dir;
  } sq_out_t;

  function automatic coord_t sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi_lim;
    logic signed [SAT_W-1:0] lo_lim;
    hi_lim = SAT_W'($signed({1'b0, {(COORD_W-1){1'b1}}}));
    lo_lim = SAT_W'($signed({1'b1, {(COORD_W-1){1'b0}}}));
    if (v > hi_lim) begin
      return coord_t'(hi_lim);
    end else if (v < lo_lim) begin
      return coord_t'(lo_lim);
    end else begin
      return coord_t'(v);
    end
  endfunction

endpackage
`default_nettype wire

// ----- design/rsi_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_in_if / rsi_out_if - valid/ready channels of the intersection block
// One interface carries the ray and sphere item, the other the result item.
// ----------------------------------------------------------------------------
interface rsi_in_if;
  import rsi_pkg::*;
  logic   valid;
  logic   ready;
  coord_t origin_x;
  coord_t origin_y;
  coord_t origin_z;
  dir_t   dir_x;
  dir_t   dir_y;
  dir_t   dir_z;
  coord_t center_x;
  coord_t center_y;
  coord_t center_z;
  logic [RAD_IN_W-1:0] radius;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  center_x, center_y, center_z, radius, input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  center_x, center_y, center_z, radius, output ready);
endinterface

interface rsi_out_if;
  import rsi_pkg::*;
  logic   valid;
  logic   ready;
  logic   hit;
  coord_t distance;
  coord_t hit_x;
  coord_t hit_y;
  coord_t hit_z;

  modport source (output valid, hit, distance, hit_x, hit_y, hit_z, input ready);
  modport sink   (input valid, hit, distance, hit_x, hit_y, hit_z, output ready);
endinterface
`default_nettype wire

// ----- design/ray_sphere_intersect.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ray_sphere_intersect - fixed-point ray / sphere intersection test
// Forms the quadratic discriminant of a ray against a sphere, takes its exact
// integer square root and reports the far root and the point it gives.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake     Payload
//   in_ch     sink        valid/ready   ray origin, direction, centre, radius
//   out_ch    source      valid/ready   hit, distance, hit_x/y/z
//
// An item may be accepted in every cycle unless a stall on the result side
// has backed up to in_ch; the depth is set by the square root, which
// resolves one root bit per stage.
// Reset is synchronous and active low; it clears only the valid bits.
// Every stage holds its item while the stage after it is full and stalled,
// so a stall on the result side fills empty stages before it reaches in_ch.
//
module ray_sphere_intersect (
  input  logic      clk,
  input  logic      rst_n,
  rsi_in_if.sink    in_ch,
  rsi_out_if.source out_ch
);
  import rsi_pkg::*;

  in_t     in_item;
  out_t    out_item;
  sq_in_t  front_data;
  sq_out_t root_data;
  logic    front_valid;
  logic    front_ready;
  logic    root_valid;
  logic    root_ready;

  // Gather the channel's fields into the item struct.
  assign in_item.origin = {in_ch.origin_z, in_ch.origin_y, in_ch.origin_x};
  assign in_item.dir    = {in_ch.dir_z, in_ch.dir_y, in_ch.dir_x};
  assign in_item.center = {in_ch.center_z, in_ch.center_y, in_ch.center_x};
  assign in_item.radius = in_ch.radius;

  // The front section works out d.w, w.w and r*r, then the discriminant.
  rsi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_data  (in_item),
    .dn_valid (front_valid),
    .dn_ready (front_ready),
    .dn_data  (front_data)
  );

  // The square root pipeline carries the other fields alongside the root.
  rsi_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (front_valid),
    .up_ready (front_ready),
    .up_data  (front_data),
    .dn_valid (root_valid),
    .dn_ready (root_ready),
    .dn_data  (root_data)
  );

  // The back section forms the distance and the point; its last stage is
  // the output register.
  rsi_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (root_valid),
    .up_ready (root_ready),
    .up_data  (root_data),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_data  (out_item)
  );

  assign out_ch.hit      = out_item.hit;
  assign out_ch.distance = out_item.distance;
  assign out_ch.hit_x    = out_item.point[0];
  assign out_ch.hit_y    = out_item.point[1];
  assign out_ch.hit_z    = out_item.point[2];

endmodule
`default_nettype wire

// ----- design/rsi_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_front - dot products and discriminant
// Six register stages: w = o - c, products, sums, partial squares of d.w,
// the square itself, and the signed discriminant with the hit flag.
// ----------------------------------------------------------------------------
module rsi_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  rsi_pkg::in_t    up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output rsi_pkg::sq_in_t dn_data
);
  import rsi_pkg::*;

  logic [5:0] v_r;
  logic [5:0] en;

  // Stage 1
  coord_t [2:0] o1_r;
  dir_t   [2:0] d1_r;
  logic signed [W_W-1:0] w1_r [3];
  logic [RAD_IN_W-1:0] rad1_r;
  // Stage 2
  coord_t [2:0] o2_r;
  dir_t   [2:0] d2_r;
  logic signed [PROD_W-1:0] p2_r [3];
  logic [WSQ_W-1:0] wsq2_r [3];
  logic [RR_W-1:0] rr2_r;
  // Stage 3
  coord_t [2:0] o3_r;
  dir_t   [2:0] d3_r;
  dot_t dot3_r;
  logic [WW_W-1:0] ww3_r;
  logic [RR_W-1:0] rr3_r;
  // Stage 4
  coord_t [2:0] o4_r;
  dir_t   [2:0] d4_r;
  dot_t dot4_r;
  logic [2*MAG_LO_W-1:0] pll4_r;
  logic [MAG_LO_W+MAG_HI_W-1:0] plh4_r;
  logic [2*MAG_HI_W-1:0] phh4_r;
  logic [DIFF_W-1:0] neg4_r;
  logic [DIFF_W-1:0] rrs4_r;
  // Stage 5
  coord_t [2:0] o5_r;
  dir_t   [2:0] d5_r;
  dot_t dot5_r;
  logic [DSQ_W-1:0] dsq5_r;
  logic [DIFF_W-1:0] neg5_r;
  logic [DIFF_W-1:0] rrs5_r;
  // Stage 6
  sq_in_t out6_r;

  logic [W_W-1:0] wmag [3];
  logic [DOT_W-1:0] dmag;
  logic [DIFF_W-1:0] diff;

  assign en[5]    = ~v_r[5] | dn_ready;
  assign en[4]    = ~v_r[4] | en[5];
  assign en[3]    = ~v_r[3] | en[4];
  assign en[2]    = ~v_r[2] | en[3];
  assign en[1]    = ~v_r[1] | en[2];
  assign en[0]    = ~v_r[0] | en[1];
  assign up_ready = en[0];
  assign dn_valid = v_r[5];
  assign dn_data  = out6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
      if (en[4]) v_r[4] <= v_r[3];
      if (en[5]) v_r[5] <= v_r[4];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wmag[i] = w1_r[i][W_W-1] ? W_W'(-w1_r[i]) : W_W'(w1_r[i]);
    end
    dmag = dot3_r[DOT_W-1] ? DOT_W'(-dot3_r) : DOT_W'(dot3_r);
    diff = DIFF_W'(dsq5_r) + rrs5_r - neg5_r;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      o1_r   <= up_data.origin;
      d1_r   <= up_data.dir;
      rad1_r <= up_data.radius;
      for (int i = 0; i < 3; i++) begin
        w1_r[i] <= W_W'(up_data.origin[i]) - W_W'(up_data.center[i]);
      end
    end
    if (en[1]) begin
      o2_r  <= o1_r;
      d2_r  <= d1_r;
      rr2_r <= RR_W'(rad1_r) * RR_W'(rad1_r);
      for (int i = 0; i < 3; i++) begin
        p2_r[i]   <= PROD_W'(d1_r[i]) * PROD_W'(w1_r[i]);
        wsq2_r[i] <= WSQ_W'(wmag[i]) * WSQ_W'(wmag[i]);
      end
    end
    if (en[2]) begin
      o3_r   <= o2_r;
      d3_r   <= d2_r;
      rr3_r  <= rr2_r;
      dot3_r <= DOT_W'(p2_r[0]) + DOT_W'(p2_r[1]) + DOT_W'(p2_r[2]);
      ww3_r  <= WW_W'(wsq2_r[0]) + WW_W'(wsq2_r[1]) + WW_W'(wsq2_r[2]);
    end
    if (en[3]) begin
      o4_r   <= o3_r;
      d4_r   <= d3_r;
      dot4_r <= dot3_r;
      pll4_r <= (2*MAG_LO_W)'(dmag[MAG_LO_W-1:0]) * (2*MAG_LO_W)'(dmag[MAG_LO_W-1:0]);
      plh4_r <= (MAG_LO_W+MAG_HI_W)'(dmag[MAG_LO_W-1:0])
              * (MAG_LO_W+MAG_HI_W)'(dmag[DOT_W-1:MAG_LO_W]);
      phh4_r <= (2*MAG_HI_W)'(dmag[DOT_W-1:MAG_LO_W])
              * (2*MAG_HI_W)'(dmag[DOT_W-1:MAG_LO_W]);
      neg4_r <= DIFF_W'(ww3_r) << (2 * FRAC_BITS);
      rrs4_r <= DIFF_W'(rr3_r) << (2 * FRAC_BITS);
    end
    if (en[4]) begin
      o5_r   <= o4_r;
      d5_r   <= d4_r;
      dot5_r <= dot4_r;
      neg5_r <= neg4_r;
      rrs5_r <= rrs4_r;
      // |dot|^2 = lo^2 + 2*lo*hi*2^32 + hi^2*2^64
      dsq5_r <= DSQ_W'(pll4_r) + (DSQ_W'(plh4_r) << (MAG_LO_W + 1))
              + (DSQ_W'(phh4_r) << (2 * MAG_LO_W));
    end
    if (en[5]) begin
      out6_r.hit    <= ~diff[DIFF_W-1];
      out6_r.dq     <= diff[DQ_W-1:0];
      out6_r.dot    <= dot5_r;
      out6_r.origin <= o5_r;
      out6_r.dir    <= d5_r;
    end
  end

endmodule
`default_nettype wire

// ----- design/rsi_sqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_sqrt - pipelined integer square root
// One restoring digit step per register stage, two radicand bits per step.
// ----------------------------------------------------------------------------
module rsi_sqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  rsi_pkg::sq_in_t  up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output rsi_pkg::sq_out_t dn_data
);
  import rsi_pkg::*;

  typedef struct packed {
    logic               hit;
    logic [REM_W-1:0]   rem;
    logic [SQ_W-1:0]    root;
    logic [RADIC_W-1:0] radic;
    dot_t               dot;
    coord_t [2:0]       origin;
    dir_t   [2:0]       dir;
  } sq_stage_t;

  logic      v_r   [SQ_W];
  sq_stage_t stg_r [SQ_W];
  logic      en    [SQ_W];
  logic      src_v [SQ_W];
  sq_stage_t src   [SQ_W];
  sq_stage_t head;

  always_comb begin
    head.hit    = up_data.hit;
    head.rem    = '0;
    head.root   = '0;
    head.radic  = RADIC_W'(up_data.dq);
    head.dot    = up_data.dot;
    head.origin = up_data.origin;
    head.dir    = up_data.dir;
  end

  assign up_ready = en[0];

  for (genvar j = 0; j < SQ_W; j++) begin : g_step
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;

    if (j == 0) begin : g_first
      assign src_v[j] = up_valid;
      assign src[j]   = head;
    end else begin : g_next
      assign src_v[j] = v_r[j-1];
      assign src[j]   = stg_r[j-1];
    end

    if (j == SQ_W - 1) begin : g_last
      assign en[j] = ~v_r[j] | dn_ready;
    end else begin : g_mid
      assign en[j] = ~v_r[j] | en[j+1];
    end

    assign cur   = {src[j].rem[SQ_W-1:0], src[j].radic[RADIC_W-1 -: 2]};
    assign trial = {src[j].root, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en[j]) begin
        v_r[j] <= src_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        stg_r[j].hit    <= src[j].hit;
        stg_r[j].dot    <= src[j].dot;
        stg_r[j].origin <= src[j].origin;
        stg_r[j].dir    <= src[j].dir;
        stg_r[j].radic  <= src[j].radic << 2;
        if (cur >= trial) begin
          stg_r[j].rem  <= cur - trial;
          stg_r[j].root <= {src[j].root[SQ_W-2:0], 1'b1};
        end else begin
          stg_r[j].rem  <= cur;
          stg_r[j].root <= {src[j].root[SQ_W-2:0], 1'b0};
        end
      end
    end
  end

  assign dn_valid       = v_r[SQ_W-1];
  assign dn_data.hit    = stg_r[SQ_W-1].hit;
  assign dn_data.root   = stg_r[SQ_W-1].root;
  assign dn_data.dot    = stg_r[SQ_W-1].dot;
  assign dn_data.origin = stg_r[SQ_W-1].origin;
  assign dn_data.dir    = stg_r[SQ_W-1].dir;

endmodule
`default_nettype wire

// ----- design/rsi_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_back - distance and intersection point
// Three register stages: far root and saturated distance, distance times
// direction, point sum with saturation. The last stage is the output register.
// ----------------------------------------------------------------------------
module rsi_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  rsi_pkg::sq_out_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output rsi_pkg::out_t    dn_data
);
  import rsi_pkg::*;

  logic [2:0] v_r;
  logic [2:0] en;

  logic         hit1_r;
  coord_t       dist1_r;
  coord_t [2:0] o1_r;
  dir_t   [2:0] d1_r;

  logic         hit2_r;
  coord_t       dist2_r;
  coord_t [2:0] o2_r;
  logic signed [DPROD_W-1:0] prod2_r [3];

  out_t out3_r;

  logic signed [T_W-1:0]  t_far;
  logic signed [T_W-1:0]  t_shr;
  logic signed [PT_W-1:0] pt [3];

  assign en[2]    = ~v_r[2] | dn_ready;
  assign en[1]    = ~v_r[1] | en[2];
  assign en[0]    = ~v_r[0] | en[1];
  assign up_ready = en[0];
  assign dn_valid = v_r[2];
  assign dn_data  = out3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_comb begin
    t_far = T_W'($signed({1'b0, up_data.root})) - T_W'(up_data.dot);
    t_shr = t_far >>> FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      pt[i] = PT_W'(o2_r[i]) + PT_W'(prod2_r[i] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hit1_r  <= up_data.hit;
      dist1_r <= sat32(SAT_W'(t_shr));
      o1_r    <= up_data.origin;
      d1_r    <= up_data.dir;
    end
    if (en[1]) begin
      hit2_r  <= hit1_r;
      dist2_r <= dist1_r;
      o2_r    <= o1_r;
      for (int i = 0; i < 3; i++) begin
        prod2_r[i] <= DPROD_W'(dist1_r) * DPROD_W'(d1_r[i]);
      end
    end
    if (en[2]) begin
      out3_r.hit      <= hit2_r;
      out3_r.distance <= hit2_r ? dist2_r : '0;
      for (int i = 0; i < 3; i++) begin
        out3_r.point[i] <= hit2_r ? sat32(SAT_W'(pt[i])) : '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for ray_sphere_intersect
// Drives ray and sphere items through the valid/ready input channel, predicts
// each result with a wide-integer model of the quadratic test and compares it
// field by field with what leaves the result channel, under random idling on
// both sides.
// ----------------------------------------------------------------------------
module testbench;
  import rsi_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 100;     // a little more than the pipeline depth
  localparam int UNIT        = 1 << FRAC_BITS;

  typedef struct packed {
    coord_t [2:0]        origin;
    dir_t   [2:0]        dir;
    coord_t [2:0]        center;
    logic [RAD_IN_W-1:0] radius;
  } ray_t;

  typedef struct packed {
    logic   hit;
    coord_t distance;
    coord_t [2:0] point;
  } hit_rec_t;

  // One row of the directed table: a ray, and optionally a result typed in.
  typedef struct packed {
    ray_t     ray;
    logic     typed;
    hit_rec_t want;
  } row_t;

  logic clk;
  logic rst_n;

  rsi_in_if  in_ch ();
  rsi_out_if out_ch ();

  ray_sphere_intersect i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hit_rec_t pending_hits[$];
  row_t     rows[$];
  int       errors;
  int       cycles;
  int       n_hits;
  int       n_misses;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturates a wide signed value to the signed 32-bit range.
  function automatic coord_t clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return coord_t'(v);
  endfunction

  // Works out the expected result of one ray / sphere test. All intermediates
  // are exact: w = o - c, dot = d.w, and the quarter discriminant
  // dot^2 - (w.w - r^2) * 2^(2F) decides the hit; the far root is then
  // -dot + floor(sqrt(disc)).
  function automatic hit_rec_t trace_ray(input ray_t r);
    logic signed [63:0]  w[3];
    logic signed [63:0]  d[3];
    logic signed [63:0]  dot;
    logic signed [63:0]  t;
    logic signed [63:0]  dist_s;
    logic signed [63:0]  p;
    logic signed [127:0] ww;
    logic signed [127:0] rad;
    logic signed [127:0] dot_w;
    logic signed [127:0] pos;
    logic signed [127:0] neg;
    logic [127:0]        disc;
    logic [127:0]        cand_sq;
    logic [63:0]         root;
    logic [63:0]         cand;
    hit_rec_t            res;
    dot = 0;
    ww  = 0;
    for (int i = 0; i < 3; i++) begin
      w[i] = 64'(r.origin[i]);
      w[i] = w[i] - 64'(r.center[i]);
      d[i] = 64'(r.dir[i]);
      dot  = dot + d[i] * w[i];
      ww   = ww + 128'(w[i]) * 128'(w[i]);
    end
    rad   = $signed({97'b0, r.radius});
    dot_w = 128'(dot);
    pos   = dot_w * dot_w + ((rad * rad) <<< (2 * FRAC_BITS));
    neg   = ww <<< (2 * FRAC_BITS);
    res   = '0;
    if (pos < neg) begin
      return res;
    end
    disc = $unsigned(pos - neg);
    root = 0;
    for (int k = 62; k >= 0; k--) begin
      cand    = root | (64'd1 << k);
      cand_sq = 128'(cand) * 128'(cand);
      if (cand_sq <= disc) begin
        root = cand;
      end
    end
    t      = $signed(root) - dot;
    dist_s = 64'(clamp32(t >>> FRAC_BITS));
    res.hit      = 1'b1;
    res.distance = coord_t'(dist_s);
    for (int i = 0; i < 3; i++) begin
      p = 64'(r.origin[i]) + ((dist_s * d[i]) >>> FRAC_BITS);
      res.point[i] = clamp32(p);
    end
    return res;
  endfunction

  function automatic ray_t make_ray(input int ox, input int oy, input int oz,
                                    input int dx, input int dy, input int dz,
                                    input int cx, input int cy, input int cz,
                                    input int rad);
    ray_t r;
    r.origin = {coord_t'(oz), coord_t'(oy), coord_t'(ox)};
    r.dir    = {dir_t'(dz), dir_t'(dy), dir_t'(dx)};
    r.center = {coord_t'(cz), coord_t'(cy), coord_t'(cx)};
    r.radius = RAD_IN_W'(rad);
    return r;
  endfunction

  task automatic add_row(input ray_t r, input logic typed, input hit_rec_t want);
    row_t row;
    row.ray   = r;
    row.typed = typed;
    row.want  = want;
    rows.push_back(row);
  endtask

  // Random ray: mostly a plausible scene with a near-unit direction and a
  // sphere not far from the origin, sometimes every bit left to chance.
  function automatic ray_t random_ray();
    ray_t         r;
    logic [287:0] bits;
    int           span;
    int           ax;
    r = '0;
    if ($urandom_range(0, 3) == 0) begin
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom};
      r = bits[$bits(ray_t)-1:0];
      return r;
    end
    span = ($urandom_range(0, 4) == 0) ? 32'h3fffffff : (64 * UNIT);
    for (int i = 0; i < 3; i++) begin
      r.origin[i] = coord_t'($signed($urandom_range(0, 2 * span)) - span);
      r.center[i] = coord_t'(r.origin[i] + $signed($urandom_range(0, 32 * UNIT))
                             - 16 * UNIT);
      r.dir[i]    = dir_t'($signed($urandom_range(0, 2 * UNIT / 2)) - UNIT / 2);
    end
    // Lean the direction towards the sphere along one axis.
    ax = $urandom_range(0, 2);
    r.dir[ax] = (r.center[ax] >= r.origin[ax]) ? dir_t'(UNIT - $urandom_range(0, 8192))
                                               : dir_t'(-UNIT + $urandom_range(0, 8192));
    r.radius = RAD_IN_W'($urandom_range(0, 12 * UNIT));
    return r;
  endfunction

  // Gap length: usually none or short, now and then long.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Sender. Each item is pushed onto the expected store at the edge where it
  // is accepted; a follow-on item is driven in that same step, so valid is
  // only lowered when a gap really follows.
  task automatic send_ray(input ray_t r, input hit_rec_t want, input bit quiet);
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.origin_x <= r.origin[0];
    in_ch.origin_y <= r.origin[1];
    in_ch.origin_z <= r.origin[2];
    in_ch.dir_x    <= r.dir[0];
    in_ch.dir_y    <= r.dir[1];
    in_ch.dir_z    <= r.dir[2];
    in_ch.center_x <= r.center[0];
    in_ch.center_y <= r.center[1];
    in_ch.center_z <= r.center[2];
    in_ch.radius   <= r.radius;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_hits.push_back(want);
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Inputs start at known values; reset is held low once, at the start.
  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.origin_x <= '0;
    in_ch.origin_y <= '0;
    in_ch.origin_z <= '0;
    in_ch.dir_x    <= '0;
    in_ch.dir_y    <= '0;
    in_ch.dir_z    <= '0;
    in_ch.center_x <= '0;
    in_ch.center_y <= '0;
    in_ch.center_z <= '0;
    in_ch.radius   <= '0;
    rst_n          <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Receiver: random stalls on ready, and the check of every accepted result
  // against the oldest expectation.
  int stall_left;
  int calm_left;

  always @(posedge clk) begin
    hit_rec_t want;
    hit_rec_t got;
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
      calm_left    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.hit, out_ch.distance, out_ch.hit_z, out_ch.hit_y, out_ch.hit_x};
        if (pending_hits.size() == 0) begin
          $error("result item arrived with nothing expected");
          errors++;
        end else begin
          want = pending_hits.pop_front();
          if (got.hit) n_hits++; else n_misses++;
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, got.hit);
            errors++;
          end
          if (got.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, got.distance);
            errors++;
          end
          if (got.point[0] !== want.point[0]) begin
            $error("hit_x: expected %0d, got %0d", want.point[0], got.point[0]);
            errors++;
          end
          if (got.point[1] !== want.point[1]) begin
            $error("hit_y: expected %0d, got %0d", want.point[1], got.point[1]);
            errors++;
          end
          if (got.point[2] !== want.point[2]) begin
            $error("hit_z: expected %0d, got %0d", want.point[2], got.point[2]);
            errors++;
          end
        end
      end
      // Stretches of steady readiness alternate with random stalls.
      if (calm_left > 0) begin
        calm_left    <= calm_left - 1;
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 39) == 0) begin
        calm_left    <= $urandom_range(20, 80);
        out_ch.ready <= 1'b1;
      end else begin
        stall_left   <= idle_len();
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a run that hangs is a failure.
  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycles, pending_hits.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    hit_rec_t want;
    hit_rec_t none;
    hit_rec_t typed_hit;
    ray_t     r;
    errors       = 0;
    cycles       = 0;
    n_hits       = 0;
    n_misses     = 0;
    none         = '0;

    // Directed table. Typed-in results only where the arithmetic is obvious.
    // All zero: a zero-radius sphere at the origin is touched at distance zero.
    typed_hit = '0;
    typed_hit.hit = 1'b1;
    add_row(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, typed_hit);
    // Unit sphere ten units along +x: the far side is at eleven units.
    typed_hit.distance = 11 * UNIT;
    typed_hit.point    = {coord_t'(0), coord_t'(0), coord_t'(11 * UNIT)};
    add_row(make_ray(0, 0, 0, UNIT, 0, 0, 10 * UNIT, 0, 0, UNIT), 1'b1, typed_hit);
    // Same sphere, ray along +y: a clean miss with every field zero.
    add_row(make_ray(0, 0, 0, 0, UNIT, 0, 10 * UNIT, 0, 0, UNIT), 1'b1, none);
    // Sphere behind the ray: the far root lies at a negative distance.
    add_row(make_ray(0, 0, 0, UNIT, 0, 0, -10 * UNIT, 0, 0, UNIT), 1'b0, none);
    // Origin inside the sphere.
    add_row(make_ray(UNIT, 0, 0, 0, 0, -UNIT, 0, 0, 0, 5 * UNIT), 1'b0, none);
    // Grazing tangent: discriminant exactly zero.
    add_row(make_ray(0, UNIT, 0, UNIT, 0, 0, 4 * UNIT, 0, 0, UNIT), 1'b0, none);
    // Negative unit directions on each axis.
    add_row(make_ray(0, 0, 0, -UNIT, 0, 0, -3 * UNIT, 0, 0, UNIT), 1'b0, none);
    add_row(make_ray(0, 0, 0, 0, -UNIT, 0, 0, -3 * UNIT, 0, UNIT), 1'b0, none);
    add_row(make_ray(0, 0, 0, 0, 0, -UNIT, 0, 0, -3 * UNIT, UNIT), 1'b0, none);
    // Direction fields at their encoding extremes, not unit length.
    add_row(make_ray(0, 0, 0, 131071, 131071, 131071, UNIT, UNIT, UNIT, 2 * UNIT),
            1'b0, none);
    add_row(make_ray(0, 0, 0, -131072, -131072, -131072, -UNIT, 0, UNIT, 3 * UNIT),
            1'b0, none);
    // Coordinate extremes: origin and centre at opposite corners.
    add_row(make_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, -UNIT, 0, 0,
                     32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff),
            1'b0, none);
    add_row(make_ray(32'h80000000, 32'h80000000, 32'h80000000, UNIT, 0, 0,
                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0), 1'b0, none);
    // Largest radius around the origin.
    add_row(make_ray(0, 0, 0, UNIT, UNIT, UNIT, 0, 0, 0, 32'h7fffffff), 1'b0, none);
    add_row(make_ray(32'h7fff0000, 0, 32'h80000000, UNIT, 0, -UNIT, 0, 0, 0,
                     32'h7fffffff), 1'b0, none);
    // All ones and alternating bit patterns.
    add_row(make_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, 32'h7fffffff), 1'b0, none);
    add_row(make_ray(32'h55555555, 32'haaaaaaaa, 32'h55555555, 18'h15555, 18'h2aaaa,
                     18'h15555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                     32'h2aaaaaaa), 1'b0, none);

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    foreach (rows[i]) begin
      want = rows[i].typed ? rows[i].want : trace_ray(rows[i].ray);
      send_ray(rows[i].ray, want, 1'b0);
    end

    // Random part, with some back-to-back stretches with no gaps at all.
    for (int n = 0; n < 450; n++) begin
      r = random_ray();
      send_ray(r, trace_ray(r), (n / 50) % 3 == 1);
    end
    in_ch.valid  <= 1'b0;

    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d ray items checked: %0d hits, %0d misses, %0d directed rows",
             n_hits + n_misses, n_hits, n_misses, rows.size());
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
